[rtl/csel_pkg.sv]
// ----------------------------------------------------------------------------
// csel_pkg
// Shared types and codes for the charger status event limiter.
// ----------------------------------------------------------------------------
package csel_pkg;

    localparam int unsigned TICK_W = 32;

    // Item operation codes
    localparam logic [1:0] OP_PLUG_EDGE = 2'd0;
    localparam logic [1:0] OP_CHG_EDGE  = 2'd1;
    localparam logic [1:0] OP_POLL      = 2'd2;

    // Last reported state encoding
    localparam logic [1:0] ST_OFF     = 2'd0;
    localparam logic [1:0] ST_ON      = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 32'd16384;

    // Tracking state of one watched signal
    typedef struct packed {
        logic [1:0]        last;
        logic              stamp_valid;
        logic [TICK_W-1:0] stamp;
    } sig_state_t;

endpackage

[rtl/csel_in_if.sv]
// ----------------------------------------------------------------------------
// csel_in_if
// Input item channel: valid/ready with timestamp and pin levels.
// ----------------------------------------------------------------------------
interface csel_in_if;
    import csel_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [TICK_W-1:0] now_ticks;
    logic              power_good_level;
    logic              charging_status_level;

    modport source (
        output valid,
        output opcode,
        output now_ticks,
        output power_good_level,
        output charging_status_level,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  now_ticks,
        input  power_good_level,
        input  charging_status_level,
        output ready
    );

endinterface

[rtl/csel_out_if.sv]
// ----------------------------------------------------------------------------
// csel_out_if
// Result channel: valid/ready with reported events and state.
// ----------------------------------------------------------------------------
interface csel_out_if;
    import csel_pkg::*;

    logic              valid;
    logic              ready;
    logic              plugged_event;
    logic              plugged_value;
    logic              charging_event;
    logic              charging_value;
    logic              charge_complete_release;
    logic [TICK_W-1:0] suppressed_count;

    modport source (
        output valid,
        output plugged_event,
        output plugged_value,
        output charging_event,
        output charging_value,
        output charge_complete_release,
        output suppressed_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  plugged_event,
        input  plugged_value,
        input  charging_event,
        input  charging_value,
        input  charge_complete_release,
        input  suppressed_count,
        output ready
    );

endinterface

[rtl/charger_status_event_limiter.sv]
// ----------------------------------------------------------------------------
// charger_status_event_limiter
// Debounced change reporting for the power-good and charging-status pins.
// ----------------------------------------------------------------------------
// Each input transfer (a plugged-pin edge, a charging-pin edge or a poll)
// yields exactly one result transfer. A transfer lands in an input register;
// one pass through the change checks then updates the tracking state and
// loads the result register, so the block takes one item per cycle unless the
// result side stalls, the rate being set by that single compare-and-update
// pass between the two registers. A change inside debounce_ticks of the last
// accepted change of the same signal is deferred and counted in
// suppressed_count (wrapping). Pin levels are active low. Write
// debounce_ticks through cfg_we/cfg_wdata only while no item is in flight.
// ----------------------------------------------------------------------------
module charger_status_event_limiter
    import csel_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [TICK_W-1:0] cfg_wdata,
    csel_in_if.sink           item,
    csel_out_if.source        result
);

    // Configuration
    logic [TICK_W-1:0] debounce_reg;

    // Input register
    logic              in_valid_reg;
    logic [1:0]        in_op_reg;
    logic [TICK_W-1:0] in_now_reg;
    logic              in_pg_reg;
    logic              in_cs_reg;

    // Tracking state
    sig_state_t        plugged_reg,  plugged_next;
    sig_state_t        charging_reg, charging_next;
    logic [TICK_W-1:0] deferred_reg, deferred_next;
    logic              release_reg,  release_next;

    // Result register
    logic              out_valid_reg;
    logic              out_pev_reg;
    logic              out_cev_reg;

    logic advance;
    logic plug_en, chg_en;
    logic plugged_seen, charging_seen;
    logic pev, cev, pdefer, cdefer;

    // Advance the input register when the result register is free or drains
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    assign plugged_seen  = !in_pg_reg;
    assign charging_seen = !in_cs_reg;

    // Decode which signals this item checks; unknown codes touch nothing
    always_comb
    begin
        plug_en      = 1'b0;
        chg_en       = 1'b0;
        release_next = release_reg;
        case (in_op_reg)
            OP_PLUG_EDGE:
            begin
                plug_en      = 1'b1;
                release_next = plugged_seen && !charging_seen;
            end
            OP_CHG_EDGE:
            begin
                chg_en       = 1'b1;
                release_next = plugged_seen && !charging_seen;
            end
            OP_POLL:
            begin
                plug_en = 1'b1;
                chg_en  = 1'b1;
            end
            default:
            begin
                plug_en = 1'b0;
                chg_en  = 1'b0;
            end
        endcase
    end

    csel_check u_plug_check (
        .enable         (plug_en),
        .seen           (plugged_seen),
        .now_ticks      (in_now_reg),
        .debounce_ticks (debounce_reg),
        .cur            (plugged_reg),
        .nxt            (plugged_next),
        .fire           (pev),
        .defer          (pdefer)
    );

    csel_check u_chg_check (
        .enable         (chg_en),
        .seen           (charging_seen),
        .now_ticks      (in_now_reg),
        .debounce_ticks (debounce_reg),
        .cur            (charging_reg),
        .nxt            (charging_next),
        .fire           (cev),
        .defer          (cdefer)
    );

    // A poll may defer both signals at once: add both
    assign deferred_next = deferred_reg + TICK_W'(pdefer) + TICK_W'(cdefer);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_reg <= DEBOUNCE_RESET;
        else if (cfg_we)
            debounce_reg <= cfg_wdata;
    end

    // Input stage: capture on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_op_reg  <= item.opcode;
            in_now_reg <= item.now_ticks;
            in_pg_reg  <= item.power_good_level;
            in_cs_reg  <= item.charging_status_level;
        end
    end

    // State and result control: commit only when the item advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plugged_reg   <= '{last: ST_UNKNOWN, stamp_valid: 1'b0, stamp: '0};
            charging_reg  <= '{last: ST_UNKNOWN, stamp_valid: 1'b0, stamp: '0};
            deferred_reg  <= '0;
            release_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                plugged_reg  <= plugged_next;
                charging_reg <= charging_next;
                deferred_reg <= deferred_next;
                release_reg  <= release_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pev_reg <= pev;
            out_cev_reg <= cev;
        end
    end

    // Reported state comes straight from the committed tracking state
    assign result.valid                   = out_valid_reg;
    assign result.plugged_event           = out_pev_reg;
    assign result.plugged_value           = (plugged_reg.last == ST_ON);
    assign result.charging_event          = out_cev_reg;
    assign result.charging_value          = (charging_reg.last == ST_ON);
    assign result.charge_complete_release = release_reg;
    assign result.suppressed_count        = deferred_reg;

`ifndef SYNTHESIS
    // An unknown last state never carries a valid stamp
    a_plug_unknown_no_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (plugged_reg.last == ST_UNKNOWN) |-> !plugged_reg.stamp_valid)
        else $error("plugged stamp valid while state unknown");

    a_chg_unknown_no_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (charging_reg.last == ST_UNKNOWN) |-> !charging_reg.stamp_valid)
        else $error("charging stamp valid while state unknown");

    // The deferred count moves only when an item advances
    a_deferred_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(deferred_reg))
        else $error("suppressed count changed without an item");

    // A reported event implies the signal now holds a stamped state
    a_event_stamped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pev_reg) |-> plugged_reg.stamp_valid)
        else $error("plugged event without stamped state");
`endif

endmodule

[rtl/csel_check.sv]
// ----------------------------------------------------------------------------
// csel_check
// Change check for one signal: report, defer inside the window, or hold.
// ----------------------------------------------------------------------------
module csel_check
    import csel_pkg::*;
(
    input  logic              enable,
    input  logic              seen,
    input  logic [TICK_W-1:0] now_ticks,
    input  logic [TICK_W-1:0] debounce_ticks,
    input  sig_state_t        cur,
    output sig_state_t        nxt,
    output logic              fire,
    output logic              defer
);

    logic              differs;
    logic              in_window;
    logic [TICK_W-1:0] elapsed;

    assign differs   = (cur.last != {1'b0, seen});
    assign elapsed   = now_ticks - cur.stamp;
    assign in_window = cur.stamp_valid && (elapsed < debounce_ticks);
    assign fire      = enable && differs && !in_window;
    assign defer     = enable && differs && in_window;

    always_comb
    begin
        nxt = cur;
        if (fire)
        begin
            nxt.last        = {1'b0, seen};
            nxt.stamp_valid = 1'b1;
            nxt.stamp       = now_ticks;
        end
    end

endmodule
